@@ design/sgb_pkg.sv @@
`default_nettype none
package sgb_pkg;

  localparam int PIX_W      = 8;
  localparam int NTAPS      = 13;
  localparam int ROWS       = 16;
  localparam int ROW_SEL_W  = 4;
  localparam int MIN_SIZE   = 16;
  localparam int MAX_HEIGHT = 4096;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 13;
  localparam int CFG_W      = 13;
  localparam int PROD_W     = 16;
  localparam int SUM_W      = 18;
  localparam int RECIP_W    = 21;
  localparam int RECIP_SH   = 28;

  typedef enum logic [1:0] {
    MODE_D3  = 2'd0,
    MODE_D7A = 2'd1,
    MODE_D7B = 2'd2,
    MODE_D13 = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef logic [PIX_W-1:0] taps_t [NTAPS];

  function automatic logic [2:0] radius(input mode_t m);
    unique case (m)
      MODE_D3:  radius = 3'd1;
      MODE_D7A: radius = 3'd3;
      MODE_D7B: radius = 3'd3;
      MODE_D13: radius = 3'd6;
      default:  radius = 3'd1;
    endcase
  endfunction

  // Weight of tap i; taps beyond the window weigh zero.
  function automatic logic [7:0] weight(input mode_t m, input int i);
    int r;
    int d;
    int k;
    r = int'(radius(m));
    d = (i < r) ? (r - i) : (i - r);
    k = r - d;
    weight = 8'd0;
    if (i <= 2 * r) begin
      unique case (m)
        MODE_D7A: begin
          unique case (k)
            0: weight = 8'd1;
            1: weight = 8'd10;
            2: weight = 8'd40;
            default: weight = 8'd64;
          endcase
        end
        MODE_D7B: begin
          unique case (k)
            0: weight = 8'd71;
            1: weight = 8'd131;
            2: weight = 8'd189;
            default: weight = 8'd213;
          endcase
        end
        MODE_D13: begin
          unique case (k)
            0: weight = 8'd1;
            1: weight = 8'd5;
            2: weight = 8'd14;
            3: weight = 8'd33;
            4: weight = 8'd60;
            5: weight = 8'd88;
            default: weight = 8'd99;
          endcase
        end
        default: weight = 8'd0;
      endcase
    end
  endfunction

  // ceil(2^28 / divisor): exact quotient for sums below 2^18.
  function automatic logic [RECIP_W-1:0] recip(input mode_t m);
    unique case (m)
      MODE_D7A: recip = 21'd1617082;
      MODE_D7B: recip = 21'd269785;
      MODE_D13: recip = 21'd535800;
      default:  recip = 21'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ design/sgb_ram.sv @@
`default_nettype none
module sgb_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/sgb_kernel.sv @@
`default_nettype none
// Three stages: weighted taps, sum, divide by reciprocal multiply.
module sgb_kernel (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire sgb_pkg::mode_t                mode,
  input  wire sgb_pkg::taps_t                taps,
  output logic [sgb_pkg::PIX_W-1:0]          q
);

  logic [sgb_pkg::PROD_W-1:0] prod_next [sgb_pkg::NTAPS];
  logic [sgb_pkg::PROD_W-1:0] prod [sgb_pkg::NTAPS];
  sgb_pkg::mode_t mode_p;
  sgb_pkg::mode_t mode_s;
  logic [sgb_pkg::SUM_W+1:0] sum_next;
  logic [sgb_pkg::SUM_W-1:0] sum;
  logic [sgb_pkg::SUM_W+sgb_pkg::RECIP_W-1:0] scaled;

  always_comb begin
    for (int i = 0; i < sgb_pkg::NTAPS; i++) begin
      if (mode == sgb_pkg::MODE_D3) begin
        // 3-tap mode truncates each term on its own
        if (i == 1) begin
          prod_next[i] = sgb_pkg::PROD_W'(taps[i] >> 1);
        end else if (i == 0 || i == 2) begin
          prod_next[i] = sgb_pkg::PROD_W'(taps[i] >> 2);
        end else begin
          prod_next[i] = '0;
        end
      end else begin
        prod_next[i] = sgb_pkg::PROD_W'(taps[i]) *
                       sgb_pkg::PROD_W'(sgb_pkg::weight(mode, i));
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < sgb_pkg::NTAPS; i++) begin
      sum_next = sum_next + (sgb_pkg::SUM_W+2)'(prod[i]);
    end
  end

  assign scaled = (sgb_pkg::SUM_W+sgb_pkg::RECIP_W)'(sum) *
                  (sgb_pkg::SUM_W+sgb_pkg::RECIP_W)'(sgb_pkg::recip(mode_s));

  always_ff @(posedge clk) begin
    if (en) begin
      mode_p <= mode;
      prod   <= prod_next;
      mode_s <= mode_p;
      sum    <= sum_next[sgb_pkg::SUM_W-1:0];
      if (mode_s == sgb_pkg::MODE_D3) begin
        q <= sum[sgb_pkg::PIX_W-1:0];
      end else begin
        q <= scaled[sgb_pkg::RECIP_SH+sgb_pkg::PIX_W-1:sgb_pkg::RECIP_SH];
      end
    end
  end

endmodule
`default_nettype wire

@@ design/separable_gaussian_blur.sv @@
`default_nettype none
// Separable Gaussian blur for a raster-order 8-bit grayscale stream. One item
// is accepted per clock; the block holds one beat of back-pressure slack in a
// two-beat output buffer and only stalls the input when that buffer is full.
// Accepted items pass down the control pipeline to the output buffer. Raw pixels
// go to a 16-row delay memory (border passthrough) and a 13-tap shift line
// feeding the horizontal kernel; horizontal results are written to 16 row
// banks, all read at the same column so the whole vertical window is read out
// together, with the current row forwarded straight from the horizontal kernel.
// Output for pixel (y,x) appears when input (y+r, x+r) arrives, r being the
// kernel radius (1, 3, 3, 6 for modes 0..3); after the frame's pixels, any
// item counts as padding and drains the remaining rows. A flush item during
// the pixel phase is dropped. Writes to a defined register restart the frame
// position; a write to an undefined index changes nothing.
module separable_gaussian_blur #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // [7:0] pixel_in
  input  wire logic                        s_axis_tuser,  // [0] flush
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [7:0] pixel_out
  output logic                             m_axis_tlast,  // frame_last
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [sgb_pkg::CFG_W-1:0]   cfg_data
);

  localparam int CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WV  = CW + 1;
  localparam int OAW = $clog2(sgb_pkg::ROWS * MAX_WIDTH);
  localparam int RW  = sgb_pkg::ROW_W;

  typedef struct packed {
    logic           valid;
    logic           hv;       // horizontal result written
    logic           has_out;
    logic           interior;
    logic           last;
    sgb_pkg::mode_t mode;
    logic [3:0]     hrow;
    logic [CW-1:0]  hcol;
    logic [CW-1:0]  ox;
    logic [3:0]     oyb;
  } ctl_t;

  // Config registers
  logic [sgb_pkg::WIDTH_W-1:0]  image_width;
  logic [sgb_pkg::HEIGHT_W-1:0] image_height;
  sgb_pkg::mode_t               kernel_mode;
  logic                         cfg_hit;

  // Frame position
  logic [CW-1:0] col;
  logic [RW-1:0] row;

  logic [WV-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [2:0]    rad;
  logic [WV-1:0] colx;
  logic [WV-1:0] rx;
  logic [RW-1:0] rowr;
  logic          col_lt_r;
  logic [WV-1:0] ox_full;
  logic [RW-1:0] oy;
  logic          pix_phase;
  logic          has_out;
  logic          interior;
  logic          last;
  logic          hv;
  logic          en;
  logic          accept;
  logic          act;
  ctl_t          s0;
  ctl_t          c [1:7];

  sgb_pkg::taps_t             taps_now;
  logic [7:0]                 sr [sgb_pkg::NTAPS-1];
  logic [7:0]                 hq;
  logic [7:0]                 hq4;
  logic [7:0]                 vq;
  logic [7:0]                 orig_q;
  logic [7:0]                 o [2:7];
  logic [7:0]                 bank_q [sgb_pkg::ROWS];
  sgb_pkg::taps_t             win;
  logic [2:0]                 rad4;
  logic [OAW-1:0]             o_waddr;
  logic [OAW-1:0]             o_raddr;
  logic [7:0]                 res;

  // Output buffer
  logic [8:0] fq [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd640;
      image_height <= 13'd480;
      kernel_mode  <= sgb_pkg::MODE_D3;
    end else if (cfg_hit) begin
      unique case (sgb_pkg::reg_idx_t'(cfg_index))
        sgb_pkg::REG_WIDTH:  image_width  <= cfg_data[sgb_pkg::WIDTH_W-1:0];
        sgb_pkg::REG_HEIGHT: image_height <= cfg_data[sgb_pkg::HEIGHT_W-1:0];
        sgb_pkg::REG_MODE:   kernel_mode  <= sgb_pkg::mode_t'(cfg_data[1:0]);
        sgb_pkg::REG_NONE:   ;
        default:             ;
      endcase
    end
  end

  // Sizes saturated into their legal ranges
  always_comb begin
    if (image_width < sgb_pkg::WIDTH_W'(sgb_pkg::MIN_SIZE)) begin
      w_eff = WV'(sgb_pkg::MIN_SIZE);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WV'(MAX_WIDTH);
    end else begin
      w_eff = WV'(image_width);
    end
    if (image_height < sgb_pkg::HEIGHT_W'(sgb_pkg::MIN_SIZE)) begin
      h_eff = RW'(sgb_pkg::MIN_SIZE);
    end else if (32'(image_height) > 32'(sgb_pkg::MAX_HEIGHT)) begin
      h_eff = RW'(sgb_pkg::MAX_HEIGHT);
    end else begin
      h_eff = RW'(image_height);
    end
  end

  // Position of this item and of the output it releases
  always_comb begin
    rad       = sgb_pkg::radius(kernel_mode);
    colx      = WV'(col);
    rx        = WV'(rad);
    rowr      = RW'(rad);
    col_lt_r  = colx < rx;
    ox_full   = col_lt_r ? (colx + w_eff - rx) : (colx - rx);
    oy        = row - rowr - RW'(col_lt_r);
    pix_phase = row < h_eff;
    has_out   = (row > rowr) || ((row == rowr) && !col_lt_r);
    interior  = (ox_full >= rx) && (ox_full + rx <= w_eff - WV'(1)) &&
                (oy >= rowr) && (oy + rowr <= h_eff - RW'(1));
    last      = has_out && (oy == h_eff - RW'(1)) && (ox_full == w_eff - WV'(1));
    hv        = pix_phase && (colx >= WV'({rad, 1'b0}));
  end

  assign en            = (cnt != 2'd2);
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;
  assign act           = accept && !(pix_phase && s_axis_tuser);

  always_comb begin
    s0.valid    = act;
    s0.hv       = hv;
    s0.has_out  = has_out;
    s0.interior = interior;
    s0.last     = last;
    s0.mode     = kernel_mode;
    s0.hrow     = row[3:0];
    s0.hcol     = CW'(colx - rx);
    s0.ox       = ox_full[CW-1:0];
    s0.oyb      = oy[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_hit &&
                sgb_pkg::reg_idx_t'(cfg_index) != sgb_pkg::REG_NONE)) begin
      col <= '0;
      row <= '0;
    end else if (act) begin
      if (last) begin
        col <= '0;
        row <= '0;
      end else if (colx + WV'(1) == w_eff) begin
        col <= '0;
        row <= row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Horizontal taps: newest pixel at index 0
  always_comb begin
    taps_now[0] = s_axis_tdata;
    for (int i = 1; i < sgb_pkg::NTAPS; i++) begin
      taps_now[i] = sr[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (act && pix_phase) begin
      sr[0] <= s_axis_tdata;
      for (int i = 1; i < sgb_pkg::NTAPS - 1; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  // Raw pixel delay memory
  assign o_waddr = OAW'(row[3:0]) * OAW'(MAX_WIDTH) + OAW'(col);
  assign o_raddr = OAW'(oy[3:0]) * OAW'(MAX_WIDTH) + OAW'(ox_full[CW-1:0]);

  sgb_ram #(
    .DEPTH (sgb_pkg::ROWS * MAX_WIDTH),
    .AW    (OAW),
    .DW    (8)
  ) u_orig (
    .clk   (clk),
    .we    (act && pix_phase),
    .waddr (o_waddr),
    .wdata (s_axis_tdata),
    .re    (en),
    .raddr (o_raddr),
    .rdata (orig_q)
  );

  sgb_kernel u_hker (
    .clk  (clk),
    .en   (en),
    .mode (kernel_mode),
    .taps (taps_now),
    .q    (hq)
  );

  // Control and passthrough pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 7; k++) begin
        c[k] <= '0;
      end
    end else if (en) begin
      c[1] <= s0;
      for (int k = 2; k <= 7; k++) begin
        c[k] <= c[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o[2] <= orig_q;
      for (int k = 3; k <= 7; k++) begin
        o[k] <= o[k-1];
      end
      hq4 <= hq;
    end
  end

  // Horizontal row banks, one per row slot, read in parallel at one column
  for (genvar g = 0; g < sgb_pkg::ROWS; g++) begin : g_bank
    sgb_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW),
      .DW    (8)
    ) u_bank (
      .clk   (clk),
      .we    (en && c[3].valid && c[3].hv &&
              (c[3].hrow == sgb_pkg::ROW_SEL_W'(g))),
      .waddr (c[3].hcol),
      .wdata (hq),
      .re    (en),
      .raddr (c[3].ox),
      .rdata (bank_q[g])
    );
  end

  // Vertical window; bottom row is this item's own horizontal result
  always_comb begin
    rad4 = sgb_pkg::radius(c[4].mode);
    for (int i = 0; i < sgb_pkg::NTAPS; i++) begin
      if (i == int'({rad4, 1'b0})) begin
        win[i] = hq4;
      end else begin
        win[i] = bank_q[4'(c[4].oyb - 4'(rad4) + 4'(i))];
      end
    end
  end

  sgb_kernel u_vker (
    .clk  (clk),
    .en   (en),
    .mode (c[4].mode),
    .taps (win),
    .q    (vq)
  );

  always_comb begin
    if (c[7].interior) begin
      res = vq;
    end else if (c[7].mode == sgb_pkg::MODE_D13) begin
      res = '0;
    end else begin
      res = o[7];
    end
  end

  // Two-beat output buffer
  assign push          = en && c[7].valid && c[7].has_out;
  assign m_axis_tvalid = (cnt != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = fq[rp][7:0];
  assign m_axis_tlast  = fq[rp][8];

  always_ff @(posedge clk) begin
    if (push) begin
      fq[wp] <= {c[7].last, res};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire
